FILE: src/bdhc_pkg.sv
// bdhc_pkg: shared constants, class codes and structs for the button
// debounce and hold classifier. No dependencies.
`default_nettype none

package bdhc_pkg;

  localparam int SLOT_COUNT  = 4;
  localparam int NUM_BUTTONS = 4;

  localparam int DEB_W   = 8;
  localparam int PRESS_W = 16;
  localparam int CLASS_W = 2;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd2;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RST   = 8'd1;
  localparam logic [PRESS_W-1:0] HOLD_RST       = 16'd20;
  localparam logic [PRESS_W-1:0] LONG_PRESS_RST = 16'd60;

  localparam logic [CLASS_W-1:0] CLS_RELEASED = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_PRESSED  = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_HELD     = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_LONG     = 2'd3;

  typedef struct packed {
    logic [DEB_W-1:0]   debounce_ticks;
    logic [PRESS_W-1:0] hold_ticks;
    logic [PRESS_W-1:0] long_press_ticks;
  } bdhc_cfg_t;

  typedef struct packed {
    logic [CLASS_W-1:0] press_class;
    logic               level;
  } bdhc_lane_out_t;

endpackage

`default_nettype wire

FILE: src/bdhc_lane.sv
// bdhc_lane: debounce and press classification for one button.
// Depends on bdhc_pkg.
`default_nettype none

module bdhc_lane (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  wire                      raw,
  input  wire bdhc_pkg::bdhc_cfg_t cfg,
  output bdhc_pkg::bdhc_lane_out_t res
);
  import bdhc_pkg::*;

  logic               last_raw_r, last_raw_nxt;
  logic [DEB_W-1:0]   stable_r, stable_nxt;
  logic               level_r, level_nxt;
  logic [PRESS_W-1:0] press_r, press_nxt;
  logic [CLASS_W-1:0] class_r, class_nxt;
  logic [PRESS_W-1:0] press_inc;
  logic               accepted;

  always_comb begin
    last_raw_nxt = raw;
    if (raw != last_raw_r) begin
      stable_nxt = '0;
    end else if (stable_r != {DEB_W{1'b1}}) begin
      stable_nxt = stable_r + 1'b1;
    end else begin
      stable_nxt = stable_r;
    end

    press_inc = (press_r != {PRESS_W{1'b1}}) ? press_r + 1'b1 : press_r;
    accepted  = (stable_nxt >= cfg.debounce_ticks);

    press_nxt = press_inc;
    class_nxt = class_r;
    level_nxt = level_r;
    if (accepted) begin
      level_nxt = raw;
      if (raw && !level_r) begin
        class_nxt = CLS_PRESSED;
        press_nxt = '0;
      end else if (!raw && level_r) begin
        class_nxt = CLS_RELEASED;
      end else if (raw && level_r) begin
        priority if (press_inc >= cfg.long_press_ticks) begin
          class_nxt = CLS_LONG;
        end else if (press_inc >= cfg.hold_ticks) begin
          class_nxt = CLS_HELD;
        end else begin
          class_nxt = CLS_PRESSED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b0;
      stable_r   <= '0;
      level_r    <= 1'b0;
      press_r    <= '0;
      class_r    <= CLS_RELEASED;
    end else if (en) begin
      last_raw_r <= last_raw_nxt;
      stable_r   <= stable_nxt;
      level_r    <= level_nxt;
      press_r    <= press_nxt;
      class_r    <= class_nxt;
    end
  end

  // result reflects the state after this tick
  assign res.press_class = class_nxt;
  assign res.level       = level_nxt;

endmodule

`default_nettype wire

FILE: src/bdhc_merge.sv
// bdhc_merge: packs the lane results into one beat and holds it in the
// output register. Depends on bdhc_pkg.
`default_nettype none

module bdhc_merge (
  input  wire                                              clk,
  input  wire                                              rst_n,
  input  wire                                              load,
  input  wire                                              out_tready,
  input  wire bdhc_pkg::bdhc_lane_out_t [bdhc_pkg::SLOT_COUNT-1:0] lane_res,
  output logic                                             out_tvalid,
  output logic [bdhc_pkg::OUT_DATA_W-1:0]                  out_tdata,
  output logic                                             busy
);
  import bdhc_pkg::*;

  localparam int PAD_W = OUT_DATA_W - SLOT_COUNT * (CLASS_W + 1);

  logic                  valid_r, valid_nxt;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic [SLOT_COUNT*CLASS_W-1:0] classes;
  logic [SLOT_COUNT-1:0]         levels;

  always_comb begin
    for (int b = 0; b < SLOT_COUNT; b++) begin
      classes[b*CLASS_W +: CLASS_W] = lane_res[b].press_class;
      levels[b]                     = lane_res[b].level;
    end
    data_nxt  = {{PAD_W{1'b0}}, levels, classes};
    valid_nxt = load | (valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign busy       = valid_r & ~out_tready;

endmodule

`default_nettype wire

FILE: src/button_debounce_hold_classifier_unit.sv
// Top level of the four-button debouncer and press classifier.
// Depends on bdhc_pkg, bdhc_lane and bdhc_merge.
//
// Usage:
//   in_*  : one beat per update tick, in_tdata[3:0] = raw levels of buttons
//           zero to three (1 pressed), upper bits ignored.
//   out_* : one beat per input beat, out_tdata[7:0] = two-bit class of each
//           button (released, pressed, held, long press), [11:8] = debounced
//           levels, [15:12] zero.
//   cfg_* : register writes, index 0 debounce ticks, 1 hold ticks, 2 long
//           press ticks; other indexes ignored. cfg_ready is always high.
//   The result beat appears in the cycle after its input beat. While out_tready
//   is high, one beat per cycle is sustained: each button has its own lane,
//   all four update in the same cycle, and the output register is reloaded
//   while the previous result is taken.
//   Reset clears all button state and loads the default thresholds (1, 20,
//   60). When out_tready is low with a result pending, in_tready drops and
//   the held result stays unchanged until taken.
`default_nettype none

module button_debounce_hold_classifier_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // raw_zero, raw_one, raw_two, raw_three, zero pad
  input  wire  [bdhc_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // class_zero..class_three (2b each), level_zero..level_three, zero pad
  output logic [bdhc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [bdhc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [bdhc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bdhc_pkg::*;

  bdhc_cfg_t                       cfg_r;
  bdhc_lane_out_t [SLOT_COUNT-1:0] lane_res;
  logic                            accept;
  logic                            busy;

  assign cfg_ready = 1'b1;
  assign in_tready = ~busy;
  assign accept    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RST;
      cfg_r.hold_ticks       <= HOLD_RST;
      cfg_r.long_press_ticks <= LONG_PRESS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   cfg_r.debounce_ticks   <= cfg_data[DEB_W-1:0];
        REG_HOLD:       cfg_r.hold_ticks       <= cfg_data[PRESS_W-1:0];
        REG_LONG_PRESS: cfg_r.long_press_ticks <= cfg_data[PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar b = 0; b < SLOT_COUNT; b++) begin : g_lane
    if (b < NUM_BUTTONS) begin : g_on
      bdhc_lane u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept),
        .raw   (in_tdata[b]),
        .cfg   (cfg_r),
        .res   (lane_res[b])
      );
    end else begin : g_off
      assign lane_res[b] = '0;
    end
  end

  bdhc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .out_tready (out_tready),
    .lane_res   (lane_res),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .busy       (busy)
  );

endmodule

`default_nettype wire

FILE: src/bdhc_checker.sv
// bdhc_checker: port-level assertions for the classifier top level, and the
// bind that attaches them. Depends on bdhc_pkg.
`default_nettype none

module bdhc_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [bdhc_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import bdhc_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick gave no result beat");

  a_level_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8]  || out_tdata[1:0] == CLS_RELEASED) &&
                   (out_tdata[9]  || out_tdata[3:2] == CLS_RELEASED) &&
                   (out_tdata[10] || out_tdata[5:4] == CLS_RELEASED) &&
                   (out_tdata[11] || out_tdata[7:6] == CLS_RELEASED))
    else $error("released level with non-released class");

  a_no_deadlock: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a pending result");

endmodule

bind button_debounce_hold_classifier_unit bdhc_checker u_bdhc_checker (.*);

`default_nettype wire

FILE: sim/button_debounce_hold_classifier_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for button_debounce_hold_classifier_unit: directed, counter
// saturation, random press/bounce and back-pressure tests against a tick predictor.
// Depends on bdhc_pkg and the unit's RTL.
module button_debounce_hold_classifier_unit_tb;
  import bdhc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  wire                   in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  wire                   out_tvalid;
  logic                  out_tready = 1'b0;
  wire  [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  wire                   cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  button_debounce_hold_classifier_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // predictor copy of thresholds and per-button state
  logic [DEB_W-1:0]   deb_cfg;
  logic [PRESS_W-1:0] hold_cfg;
  logic [PRESS_W-1:0] long_cfg;
  logic               seen_raw   [SLOT_COUNT];
  logic [DEB_W-1:0]   stable_cnt [SLOT_COUNT];
  logic               level_q    [SLOT_COUNT];
  logic [PRESS_W-1:0] press_cnt  [SLOT_COUNT];
  logic [CLASS_W-1:0] cls_q      [SLOT_COUNT];

  logic [OUT_DATA_W-1:0] pending_q[$];

  int errors = 0;
  int results_seen = 0;
  int ticks_sent = 0;
  int cfg_writes = 0;
  int in_stalls = 0;
  int cycle_cnt = 0;
  int cls_seen [4] = '{0, 0, 0, 0};

  int       tx_gap_max = 0;
  int       tx_burst_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int       hold_off_req = 0;
  int       hold_left = 0;
  int       rx_phase = 0;

  logic gen_tgt    [SLOT_COUNT];
  int   gen_dwell  [SLOT_COUNT];
  int   gen_bounce [SLOT_COUNT];

  task automatic clear_predictor();
    deb_cfg  = DEBOUNCE_RST;
    hold_cfg = HOLD_RST;
    long_cfg = LONG_PRESS_RST;
    for (int b = 0; b < SLOT_COUNT; b++) begin
      seen_raw[b]   = 1'b0;
      stable_cnt[b] = '0;
      level_q[b]    = 1'b0;
      press_cnt[b]  = '0;
      cls_q[b]      = CLS_RELEASED;
      gen_tgt[b]    = 1'b0;
      gen_dwell[b]  = 0;
      gen_bounce[b] = 0;
    end
  endtask

  function automatic logic [OUT_DATA_W-1:0] classify_tick(input logic [SLOT_COUNT-1:0] raw);
    logic [OUT_DATA_W-1:0] res;
    res = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (raw[b] != seen_raw[b]) begin
        seen_raw[b]   = raw[b];
        stable_cnt[b] = '0;
      end else if (stable_cnt[b] != {DEB_W{1'b1}}) begin
        stable_cnt[b] = stable_cnt[b] + 1'b1;
      end
      if (press_cnt[b] != {PRESS_W{1'b1}})
        press_cnt[b] = press_cnt[b] + 1'b1;
      if (stable_cnt[b] >= deb_cfg) begin
        if (raw[b] && !level_q[b]) begin
          cls_q[b]     = CLS_PRESSED;
          press_cnt[b] = '0;
        end else if (!raw[b] && level_q[b]) begin
          cls_q[b] = CLS_RELEASED;
        end else if (raw[b] && level_q[b]) begin
          if (press_cnt[b] >= long_cfg)
            cls_q[b] = CLS_LONG;
          else if (press_cnt[b] >= hold_cfg)
            cls_q[b] = CLS_HELD;
          else
            cls_q[b] = CLS_PRESSED;
        end
        level_q[b] = raw[b];
      end
      res[2*b +: CLASS_W]      = cls_q[b];
      res[2*SLOT_COUNT + b]    = level_q[b];
    end
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    logic [OUT_DATA_W-1:0] want;
    logic                  bad;
    if (rst_n && in_tvalid && !in_tready)
      in_stalls++;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
      end else begin
        want = pending_q.pop_front();
        results_seen++;
        bad = 1'b0;
        for (int b = 0; b < SLOT_COUNT; b++) begin
          if (want[2*b +: CLASS_W] !== out_tdata[2*b +: CLASS_W])
            bad = 1'b1;
          if (want[2*SLOT_COUNT + b] !== out_tdata[2*SLOT_COUNT + b])
            bad = 1'b1;
          if (b < NUM_BUTTONS)
            cls_seen[out_tdata[2*b +: CLASS_W]]++;
        end
        if (want[OUT_DATA_W-1:3*SLOT_COUNT] !== out_tdata[OUT_DATA_W-1:3*SLOT_COUNT])
          bad = 1'b1;
        if (bad) begin
          errors++;
          $display("%0t: mismatch, expected cls %b lvl %b pad %h, actual cls %b lvl %b pad %h",
                   $time, want[2*SLOT_COUNT-1:0], want[3*SLOT_COUNT-1:2*SLOT_COUNT],
                   want[OUT_DATA_W-1:3*SLOT_COUNT], out_tdata[2*SLOT_COUNT-1:0],
                   out_tdata[3*SLOT_COUNT-1:2*SLOT_COUNT], out_tdata[OUT_DATA_W-1:3*SLOT_COUNT]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: long hold-off first, otherwise the current stall pattern
  always @(negedge clk) begin
    if (hold_off_req != 0) begin
      hold_left    = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:    out_tready <= 1'b1;
        RX_RANDOM:  out_tready <= ($urandom_range(0, 99) >= 35);
        RX_PATTERN: out_tready <= ((rx_phase % 7) < 4);
        default:    out_tready <= 1'b1;
      endcase
      rx_phase++;
    end
  end

  task automatic send_tick(input logic [SLOT_COUNT-1:0] raw);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[SLOT_COUNT-1:0] = raw;
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(classify_tick(raw));
    ticks_sent++;
    @(negedge clk);
    if (tx_gap_max > 0) begin
      if (tx_burst_left > 0) begin
        tx_burst_left--;
      end else begin
        tx_burst_left = $urandom_range(0, 15);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, tx_gap_max)) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DEBOUNCE:   deb_cfg  = data[DEB_W-1:0];
      REG_HOLD:       hold_cfg = data[PRESS_W-1:0];
      REG_LONG_PRESS: long_cfg = data[PRESS_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // press/release episodes with contact bounce, plus occasional noise ticks
  task automatic run_presses(input int n_ticks);
    logic [SLOT_COUNT-1:0] raw;
    int reach;
    reach = ((long_cfg > hold_cfg) ? long_cfg : hold_cfg) + deb_cfg + 4;
    if (reach > 150)
      reach = 150;
    for (int t = 0; t < n_ticks; t++) begin
      for (int b = 0; b < SLOT_COUNT; b++) begin
        if (gen_dwell[b] == 0) begin
          gen_tgt[b] = !gen_tgt[b];
          if (gen_tgt[b])
            gen_dwell[b] = $urandom_range(1, reach);
          else
            gen_dwell[b] = $urandom_range(1, (deb_cfg > 30) ? 40 : deb_cfg + 8);
          gen_bounce[b] = $urandom_range(0, 3);
        end
        gen_dwell[b]--;
        if (gen_bounce[b] > 0) begin
          raw[b] = 1'($urandom_range(0, 1));
          gen_bounce[b]--;
        end else begin
          raw[b] = gen_tgt[b];
        end
      end
      if ($urandom_range(0, 99) < 8)
        raw = SLOT_COUNT'($urandom_range(0, 15));
      send_tick(raw);
    end
  endtask

  task automatic test_directed_cases();
    rx_mode    = RX_RANDOM;
    tx_gap_max = 2;
    // reset thresholds: one tick of debounce
    send_tick(4'b0000);
    send_tick(4'b1111);
    send_tick(4'b1111);
    send_tick(4'b0110);
    drain();
    // zero debounce, long below hold, unused index ignored
    write_reg(REG_DEBOUNCE, 16'hA500);
    write_reg(REG_HOLD, 16'd3);
    write_reg(REG_LONG_PRESS, 16'd2);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_tick(4'b0000);
    send_tick(4'b1111);
    send_tick(4'b1111);
    send_tick(4'b1111);
    send_tick(4'b1111);
    send_tick(4'b0101);
    send_tick(4'b1010);
    send_tick(4'b0000);
    drain();
    write_reg(REG_HOLD, 16'd0);
    write_reg(REG_LONG_PRESS, 16'hFFFF);
    send_tick(4'b1111);
    send_tick(4'b1111);
    send_tick(4'b1111);
    drain();
    write_reg(REG_HOLD, 16'hFFFF);
    write_reg(REG_LONG_PRESS, 16'd0);
    send_tick(4'b1111);
    send_tick(4'b0000);
    send_tick(4'b1001);
    send_tick(4'b1001);
    drain();
  endtask

  task automatic test_counter_saturation();
    rx_mode    = RX_FREE;
    tx_gap_max = 0;
    // stable count must stick at its maximum for acceptance to continue
    write_reg(REG_DEBOUNCE, 16'h5AFF);
    write_reg(REG_HOLD, 16'd100);
    write_reg(REG_LONG_PRESS, 16'd300);
    repeat (262) send_tick(4'b1111);
    send_tick(4'b0000);
    drain();
  endtask

  task automatic test_random_presses();
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      if (phase == 0) begin
        write_reg(REG_DEBOUNCE, {8'($urandom_range(0, 255)), DEBOUNCE_RST});
        write_reg(REG_HOLD, HOLD_RST);
        write_reg(REG_LONG_PRESS, LONG_PRESS_RST);
      end else if (phase == 4) begin
        write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 65535)) & 16'hFF03);
        write_reg(REG_HOLD, 16'($urandom_range(0, 65535)));
        write_reg(REG_LONG_PRESS, 16'($urandom_range(0, 65535)));
      end else begin
        write_reg(REG_DEBOUNCE, {8'($urandom_range(0, 255)),
                                 8'((phase == 3) ? $urandom_range(5, 30) : $urandom_range(0, 4))});
        write_reg(REG_HOLD, 16'($urandom_range(0, 25)));
        write_reg(REG_LONG_PRESS, 16'($urandom_range(0, 40)));
      end
      if ($urandom_range(0, 1))
        write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
      rx_mode    = rx_mode_t'(phase % 3);
      tx_gap_max = (phase % 3 == 0) ? 0 : 1 + phase;
      run_presses(30);
    end
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(REG_DEBOUNCE, 16'd1);
    write_reg(REG_HOLD, 16'd4);
    write_reg(REG_LONG_PRESS, 16'd9);
    rx_mode      = RX_RANDOM;
    tx_gap_max   = 0;
    hold_off_req = 200;
    run_presses(40);
    drain();
  endtask

  initial begin
    clear_predictor();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_counter_saturation();
    test_random_presses();
    test_backpressure();
    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d ticks over directed, saturation, random and stall tests, %0d writes",
             ticks_sent, cfg_writes);
    $display("Checked %0d result beats: released %0d pressed %0d held %0d long %0d, stalls %0d",
             results_seen, cls_seen[0], cls_seen[1], cls_seen[2], cls_seen[3], in_stalls);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
src/bdhc_pkg.sv
src/bdhc_lane.sv
src/bdhc_merge.sv
src/button_debounce_hold_classifier_unit.sv
src/bdhc_checker.sv
sim/button_debounce_hold_classifier_unit_tb.sv
